// ===== src/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants of the relay auto controller
// Channel settings layout, time scale constants and the per-channel update
// record passed from the evaluator to the top level.
// ----------------------------------------------------------------------------
package rca_pkg;

	localparam int MAX_CH      = 8;
	localparam int SET_W       = 63;
	localparam int CFG_IDX_W   = 4;
	localparam int TEMP_W      = 16;
	localparam int HOUR_W      = 5;
	localparam int MS_W        = 32;
	localparam int CH_W        = 3;

	localparam logic [15:0] MS_PER_MIN = 16'd60000;
	localparam logic [9:0]  MS_PER_SEC = 10'd1000;

	// settings word, most significant field first
	typedef struct packed {
		logic [12:0] duration_s;
		logic [13:0] interval_min;
		logic [4:0]  off_hour;
		logic [4:0]  on_hour;
		logic [11:0] off_temp;
		logic [11:0] on_temp;
		logic        auto_en;
		logic        enable;
	} settings_t;

	typedef struct packed {
		logic valid;
		logic relay_on;
		logic stamp_we;
	} chan_upd_t;

endpackage

// ===== src/rca_ram.sv =====
// ----------------------------------------------------------------------------
// rca_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module rca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/rca_chan_eval.sv =====
// ----------------------------------------------------------------------------
// rca_chan_eval: two-stage per-channel rule evaluator
// Stage one forms the timer limits and the elapsed time from memory data;
// stage two applies temperature, hour and cycle timer rules in order.
// ----------------------------------------------------------------------------
module rca_chan_eval (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  rca_pkg::settings_t          set_in,
	input  logic [rca_pkg::MS_W-1:0]    last_ms,
	input  logic [rca_pkg::MS_W-1:0]    now,
	input  logic signed [rca_pkg::TEMP_W-1:0] temp,
	input  logic [rca_pkg::HOUR_W-1:0]  hour,
	input  logic                        relay_cur,
	output rca_pkg::chan_upd_t          upd
);

	logic                     vld_s2;
	rca_pkg::settings_t       set_s2;
	logic [rca_pkg::MS_W-1:0] d_s2;
	logic [29:0]              ivl_ms_s2;
	logic [22:0]              dur_ms_s2;

	logic [29:0] ivl_ms;
	logic [22:0] dur_ms;

	assign ivl_ms = set_in.interval_min * rca_pkg::MS_PER_MIN;
	assign dur_ms = set_in.duration_s * rca_pkg::MS_PER_SEC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		set_s2    <= set_in;
		d_s2      <= now - last_ms;
		ivl_ms_s2 <= ivl_ms;
		dur_ms_s2 <= dur_ms;
	end

	logic signed [16:0] t_ext, on_ext, off_ext;
	logic               r_t, r_h, r_c, stamp;
	logic               in_window;

	always_comb begin
		t_ext   = {temp[15], temp};
		on_ext  = $signed({5'b0, set_s2.on_temp});
		off_ext = $signed({5'b0, set_s2.off_temp});

		// temperature hysteresis
		r_t = relay_cur;
		if ((set_s2.on_temp != '0) || (set_s2.off_temp != '0)) begin
			if ((t_ext < on_ext) && !relay_cur) begin
				r_t = 1'b1;
			end else if ((t_ext > off_ext) && relay_cur) begin
				r_t = 1'b0;
			end
		end

		// hour window
		in_window = (hour >= set_s2.on_hour) && (hour < set_s2.off_hour);
		r_h = r_t;
		if ((set_s2.on_hour != '0) || (set_s2.off_hour != '0)) begin
			r_h = in_window;
		end

		// cycle timer
		r_c   = r_h;
		stamp = 1'b0;
		if ((set_s2.interval_min != '0) && (set_s2.duration_s != '0)) begin
			if (!r_h && (d_s2 >= {2'b0, ivl_ms_s2})) begin
				r_c   = 1'b1;
				stamp = 1'b1;
			end else if (r_h && (d_s2 >= {9'b0, dur_ms_s2})) begin
				r_c = 1'b0;
			end
		end

		upd.valid = vld_s2;
		if (set_s2.enable && set_s2.auto_en) begin
			upd.relay_on = r_c;
			upd.stamp_we = stamp;
		end else begin
			upd.relay_on = relay_cur;
			upd.stamp_we = 1'b0;
		end
	end

endmodule

// ===== src/multi_channel_relay_auto_controller.sv =====
// ----------------------------------------------------------------------------
// multi_channel_relay_auto_controller: relay channel state keeper
// Per-channel settings and last-switch stamps live in two RAMs; a control
// pass walks the channels through a two-stage evaluator.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per item. tuser carries the action,
//   0 = automatic control pass over all channels, 1 = manual set of one
//   channel. Output stream (m_*): exactly one result per request, carrying
//   the relay bits, the active-low pin levels and the accepted flag.
//   Configuration: cfg_we/cfg_index/cfg_data write channel settings; write
//   them only while no request is in flight. Indexes beyond the channel
//   count are dropped.
// Order of work:
//   A control pass: one channel a cycle comes out of the RAM read port, then
//   goes through one evaluator stage and the write-back; after the last
//   write-back the result register is loaded once it is free. A manual set
//   writes its relay on acceptance and loads the result register from the
//   response state. One request is worked on at a time, till its result is loaded.
// Reset: arst_n clears all relay flops, and all stamps and all settings at once
//   through per-entry valid bits; no clearing pass is needed.
// Stall: a result waits in the output register; the next request is still
//   taken, and its result is held back until the receiver takes the first.
// ----------------------------------------------------------------------------
module multi_channel_relay_auto_controller #(
	parameter int NUM_OUTPUTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// temp_reading[15:0], hour_of_day[20:16], now_ms[52:21],
	// channel[55:53], manual_on[56], zero fill above
	input  logic [63:0] s_tdata,
	// action[0]
	input  logic [0:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// relay_bits[7:0], pin_levels[15:8], accepted[16], zero fill above
	output logic [23:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic                            cfg_we,
	input  logic [rca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rca_pkg::SET_W-1:0]       cfg_data
);

	localparam int AW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
	localparam logic [AW-1:0] LAST_CH = AW'(NUM_OUTPUTS - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PASS = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;

	// unpack the request
	logic                              action;
	logic signed [rca_pkg::TEMP_W-1:0] in_temp;
	logic [rca_pkg::HOUR_W-1:0]        in_hour;
	logic [rca_pkg::MS_W-1:0]          in_now;
	logic [rca_pkg::CH_W-1:0]          in_channel;
	logic                              in_manual_on;

	assign action       = s_tuser[0];
	assign in_temp      = s_tdata[15:0];
	assign in_hour      = s_tdata[20:16];
	assign in_now       = s_tdata[52:21];
	assign in_channel   = s_tdata[55:53];
	assign in_manual_on = s_tdata[56];

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// hold the pass inputs for the whole pass
	logic signed [rca_pkg::TEMP_W-1:0] temp_q;
	logic [rca_pkg::HOUR_W-1:0]        hour_q;
	logic [rca_pkg::MS_W-1:0]          now_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			temp_q <= in_temp;
			hour_q <= in_hour;
			now_q  <= in_now;
		end
	end

	// channel state in flops: relay bits and per-entry valid marks
	logic                   relay_on_q  [NUM_OUTPUTS];
	logic [NUM_OUTPUTS-1:0] set_vld_q;
	logic [NUM_OUTPUTS-1:0] time_vld_q;

	// read sequencing
	logic          issuing_q;
	logic [AW-1:0] issue_q;
	logic          rd_s1;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] idx_s2;
	logic          set_vld_s1;
	logic          time_vld_s1;

	// RAMs
	logic                          cfg_hit;
	logic [rca_pkg::SET_W-1:0]     set_rdata;
	logic [rca_pkg::MS_W-1:0]      time_rdata;
	rca_pkg::chan_upd_t            upd;
	logic                          time_we;

	assign cfg_hit = cfg_we && ({1'b0, cfg_index} < 5'(NUM_OUTPUTS));
	assign time_we = upd.valid && upd.stamp_we;

	rca_ram #(
		.WIDTH (rca_pkg::SET_W),
		.DEPTH (NUM_OUTPUTS)
	) u_set_ram (
		.clk   (clk),
		.we    (cfg_hit),
		.waddr (cfg_index[AW-1:0]),
		.wdata (cfg_data),
		.raddr (issue_q),
		.rdata (set_rdata)
	);

	rca_ram #(
		.WIDTH (rca_pkg::MS_W),
		.DEPTH (NUM_OUTPUTS)
	) u_time_ram (
		.clk   (clk),
		.we    (time_we),
		.waddr (idx_s2),
		.wdata (now_q),
		.raddr (issue_q),
		.rdata (time_rdata)
	);

	// entries never written read as their reset value of zero
	rca_pkg::settings_t       set_s1;
	logic [rca_pkg::MS_W-1:0] last_s1;

	assign set_s1  = set_vld_s1  ? rca_pkg::settings_t'(set_rdata) : '0;
	assign last_s1 = time_vld_s1 ? time_rdata : '0;

	logic relay_cur;
	assign relay_cur = relay_on_q[idx_s2];

	rca_chan_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_s1),
		.set_in    (set_s1),
		.last_ms   (last_s1),
		.now       (now_q),
		.temp      (temp_q),
		.hour      (hour_q),
		.relay_cur (relay_cur),
		.upd       (upd)
	);

	logic manual_ok;
	assign manual_ok = ({1'b0, in_channel} < 4'(NUM_OUTPUTS));

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	// result packing
	logic [7:0] relay_bits, pin_levels;

	always_comb begin
		relay_bits = '0;
		pin_levels = '0;
		for (int i = 0; i < NUM_OUTPUTS; i++) begin
			relay_bits[i] = relay_on_q[i];
			pin_levels[i] = !relay_on_q[i];
		end
	end

	logic        acc_q;
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issuing_q   <= 1'b0;
			issue_q     <= '0;
			rd_s1       <= 1'b0;
			idx_s1      <= '0;
			idx_s2      <= '0;
			set_vld_s1  <= 1'b0;
			time_vld_s1 <= 1'b0;
			set_vld_q   <= '0;
			time_vld_q  <= '0;
			acc_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				relay_on_q[i] <= 1'b0;
			end
		end else begin
			// configuration writes mark the entry as holding data
			if (cfg_hit) begin
				set_vld_q[cfg_index[AW-1:0]] <= 1'b1;
			end

			// read issue: one channel a cycle
			rd_s1       <= issuing_q;
			idx_s1      <= issue_q;
			idx_s2      <= idx_s1;
			set_vld_s1  <= set_vld_q[issue_q];
			time_vld_s1 <= time_vld_q[issue_q];
			if (issuing_q) begin
				if (issue_q == LAST_CH) begin
					issuing_q <= 1'b0;
				end else begin
					issue_q <= issue_q + 1'b1;
				end
			end

			// write back the evaluated channel
			if (upd.valid) begin
				relay_on_q[idx_s2] <= upd.relay_on;
				if (upd.stamp_we) begin
					time_vld_q[idx_s2] <= 1'b1;
				end
			end

			// load the output register, or drop it once the receiver takes it
			if ((state_q == S_RESP) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action) begin
							acc_q <= manual_ok;
							if (manual_ok) begin
								relay_on_q[in_channel[AW-1:0]] <= in_manual_on;
							end
							state_q <= S_RESP;
						end else begin
							acc_q     <= 1'b1;
							issuing_q <= 1'b1;
							issue_q   <= '0;
							state_q   <= S_PASS;
						end
					end
				end
				S_PASS: begin
					// advance once the last channel has been written back
					if (upd.valid && (idx_s2 == LAST_CH)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && out_free) begin
			m_tdata_q <= {7'b0, acc_q, pin_levels, relay_bits};
		end
	end

endmodule

// ===== src/rca_checker.sv =====
// ----------------------------------------------------------------------------
// rca_checker: port-level checks for the relay auto controller
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module rca_checker #(
	parameter int NUM_OUTPUTS = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic [63:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] m_tdata,
	input logic        m_tvalid,
	input logic        m_tready
);

	localparam logic [8:0] ALL_CH = (9'd1 << NUM_OUTPUTS) - 9'd1;

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: no acceptance on the cycle after one
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// every valid channel shows exactly one of relay bit and pin level
	a_pins: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[7:0] ^ m_tdata[15:8]) == ALL_CH[7:0])
			&& ((m_tdata[7:0] & m_tdata[15:8]) == 8'd0))
		else $error("relay bits and pin levels disagree");

	// padding above the result fields stays clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:17] == 7'd0))
		else $error("result padding not zero");

endmodule

bind multi_channel_relay_auto_controller rca_checker #(
	.NUM_OUTPUTS (NUM_OUTPUTS)
) u_rca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

// ===== test/relay_state_checker.sv =====
// ----------------------------------------------------------------------------
// relay_state_checker: result predictor and comparator for the relay controller
// Mirrors the channel settings from the write port, keeps its own relay states
// and switch stamps, forms the expected report for each accepted request and
// compares every accepted result against the oldest waiting report.
// ----------------------------------------------------------------------------
package relay_tb_pkg;

	typedef enum logic {
		ACT_CONTROL_PASS = 1'b0,
		ACT_MANUAL_SET   = 1'b1
	} relay_action_e;

endpackage

module relay_state_checker #(
	parameter int CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// temp_reading[15:0], hour_of_day[20:16], now_ms[52:21],
	// channel[55:53], manual_on[56], zero fill above
	input  logic [63:0]                   s_tdata,
	// action[0]
	input  logic [0:0]                    s_tuser,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// relay_bits[7:0], pin_levels[15:8], accepted[16], zero fill above
	input  logic [23:0]                   m_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic [rca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rca_pkg::SET_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import relay_tb_pkg::*;

	localparam logic [31:0] MS_IN_MINUTE = 32'd60000;
	localparam logic [31:0] MS_IN_SECOND = 32'd1000;

	typedef struct packed {
		logic [7:0] relay_bits;
		logic [7:0] pin_levels;
		logic       accepted;
	} relay_report_t;

	rca_pkg::settings_t chan_cfg [8];
	logic               relay_state [8];
	logic [31:0]        switch_stamp [8];
	relay_report_t      expected_reports [$];

	// temperature, then hour window, then cycle timer; each sees the last one's state
	function automatic void apply_channel_rules(int ch, int temp, logic [4:0] hour,
						    logic [31:0] now);
		rca_pkg::settings_t s;
		logic               lit;
		logic               in_window;
		logic [31:0]        elapsed;
		s = chan_cfg[ch];
		if (!(s.enable && s.auto_en))
			return;
		lit = relay_state[ch];
		if (s.on_temp != 0 || s.off_temp != 0) begin
			if (temp < int'(s.on_temp) && !lit)
				lit = 1'b1;
			else if (temp > int'(s.off_temp) && lit)
				lit = 1'b0;
		end
		if (s.on_hour != 0 || s.off_hour != 0) begin
			in_window = (hour >= s.on_hour) && (hour < s.off_hour);
			if (in_window && !lit)
				lit = 1'b1;
			else if (!in_window && lit)
				lit = 1'b0;
		end
		if (s.interval_min != 0 && s.duration_s != 0) begin
			elapsed = now - switch_stamp[ch];
			if (!lit && elapsed >= 32'(s.interval_min) * MS_IN_MINUTE) begin
				lit = 1'b1;
				switch_stamp[ch] = now;
			end else if (lit && elapsed >= 32'(s.duration_s) * MS_IN_SECOND) begin
				lit = 1'b0;
			end
		end
		relay_state[ch] = lit;
	endfunction

	function automatic relay_report_t next_report(relay_action_e act, logic [63:0] data);
		relay_report_t rep;
		int            ch;
		rep = '0;
		rep.accepted = 1'b1;
		if (act == ACT_MANUAL_SET) begin
			ch = int'(data[55:53]);
			if (ch < CHANNELS)
				relay_state[ch] = data[56];
			else
				rep.accepted = 1'b0;
		end else begin
			for (int i = 0; i < CHANNELS; i++)
				apply_channel_rules(i, int'($signed(data[15:0])), data[20:16],
						    data[52:21]);
		end
		for (int i = 0; i < CHANNELS; i++) begin
			rep.relay_bits[i] = relay_state[i];
			rep.pin_levels[i] = !relay_state[i];
		end
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		relay_report_t got;
		relay_report_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chan_cfg[i] = '0;
				relay_state[i] = 1'b0;
				switch_stamp[i] = '0;
			end
			expected_reports.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.relay_bits = m_tdata[7:0];
				got.pin_levels = m_tdata[15:8];
				got.accepted   = m_tdata[16];
				if (expected_reports.size() == 0) begin
					$error("result with no request waiting: %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (got.relay_bits !== want.relay_bits) begin
						$error("relay_bits: expected %h, got %h",
						       want.relay_bits, got.relay_bits);
						fail_count++;
					end
					if (got.pin_levels !== want.pin_levels) begin
						$error("pin_levels: expected %h, got %h",
						       want.pin_levels, got.pin_levels);
						fail_count++;
					end
					if (got.accepted !== want.accepted) begin
						$error("accepted: expected %b, got %b",
						       want.accepted, got.accepted);
						fail_count++;
					end
				end
			end
			if (cfg_we && cfg_index < 8)
				chan_cfg[cfg_index[2:0]] = cfg_data;
			if (s_tvalid && s_tready)
				expected_reports.push_back(next_report(relay_action_e'(s_tuser[0]),
								       s_tdata));
		end
		outstanding = expected_reports.size();
	end

endmodule

// ===== test/multi_channel_relay_auto_controller_tb.sv =====
// ----------------------------------------------------------------------------
// multi_channel_relay_auto_controller_tb: stimulus and verdict for the relay controller
// Drives control passes and manual sets through the request stream with random
// gaps and back-pressure, reloads the channel settings between phases, and
// leaves prediction and comparison to the state checker beside the block.
// ----------------------------------------------------------------------------
module multi_channel_relay_auto_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import relay_tb_pkg::*;

	localparam int N_CH          = 8;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 6;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = N_CH + 8;
	localparam int IDLE_PERCENT  = 21;
	localparam int PHASE_ITEMS   = 100;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic [63:0]                   s_tdata   = '0;
	logic [0:0]                    s_tuser   = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [23:0]                   m_tdata;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [rca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rca_pkg::SET_W-1:0]     cfg_data  = '0;

	// high during one whole phase: no gaps from the sender, no stalls from the receiver
	logic                          calm      = 1'b0;
	int                            fail_count;
	int                            outstanding;
	int                            quiet_cycles = 0;
	// running millisecond clock handed to control passes
	logic [31:0]                   clock_ms  = '0;
	rca_pkg::settings_t            plan [N_CH];

	multi_channel_relay_auto_controller #(
		.NUM_OUTPUTS(N_CH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	relay_state_checker #(
		.CHANNELS(N_CH)
	) state_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tdata    (m_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver back-pressure: stall at random unless the phase is calm
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);

	// give up once nothing has moved on either stream for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [63:0] pack_request(logic [15:0] temp, logic [4:0] hour,
						     logic [31:0] now, logic [2:0] ch,
						     logic turn_on);
		return {7'b0, turn_on, ch, now, hour, temp};
	endfunction

	// present one request and hold it until the block takes it; returns on the
	// accepting edge with tvalid still high, so back-to-back requests need no dip
	task automatic send_request(relay_action_e act, logic [63:0] data);
		logic taken;
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= data;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
	endtask

	// channel and manual_on are ignored on a pass: fill them with noise
	task automatic send_pass(int temp, int hour, logic [31:0] now);
		send_request(ACT_CONTROL_PASS, pack_request(16'(temp), 5'(hour), now,
							    3'($urandom), 1'($urandom)));
	endtask

	// temperature, hour and time are ignored on a manual set: fill them with noise
	task automatic send_manual(int ch, logic turn_on);
		send_request(ACT_MANUAL_SET, pack_request(16'($urandom), 5'($urandom), $urandom,
							  3'(ch), turn_on));
	endtask

	// drop tvalid and hold until every outstanding result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	// load the plan into every channel, then hit the spare indexes with noise,
	// which the block must drop
	task automatic write_plan();
		for (int i = 0; i < N_CH; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= rca_pkg::CFG_IDX_W'(i);
			cfg_data  <= plan[i];
			@(posedge clk);
		end
		for (int i = N_CH; i < (1 << rca_pkg::CFG_IDX_W); i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= rca_pkg::CFG_IDX_W'(i);
			cfg_data  <= rca_pkg::SET_W'({$urandom, $urandom});
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly sensible thresholds, windows and short timers so that the rules
	// actually fire; now and then a raw random word
	function automatic rca_pkg::settings_t random_setting();
		rca_pkg::settings_t s;
		s = rca_pkg::settings_t'(rca_pkg::SET_W'({$urandom, $urandom}));
		if ($urandom_range(0, 3) == 0)
			return s;
		s.enable  = ($urandom_range(0, 7) != 0);
		s.auto_en = ($urandom_range(0, 7) != 0);
		if ($urandom_range(0, 3) == 0) begin
			s.on_temp  = '0;
			s.off_temp = '0;
		end else begin
			s.on_temp  = 12'($urandom_range(150, 450));
			s.off_temp = 12'($urandom_range(250, 550));
		end
		if ($urandom_range(0, 2) == 0) begin
			s.on_hour  = '0;
			s.off_hour = '0;
		end else begin
			s.on_hour  = 5'($urandom_range(0, 12));
			s.off_hour = 5'($urandom_range(6, 26));
		end
		s.interval_min = ($urandom_range(0, 2) == 0) ? 14'd0 : 14'($urandom_range(1, 4));
		s.duration_s   = ($urandom_range(0, 2) == 0) ? 13'd0 : 13'($urandom_range(1, 150));
		return s;
	endfunction

	task automatic send_random_item();
		int pick;
		int temp;
		int hour;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			send_manual($urandom_range(0, N_CH - 1), 1'($urandom));
		end else begin
			// advance the clock in realistic steps, jump now and then, or hold it
			pick = $urandom_range(0, 99);
			if (pick < 85)
				clock_ms += $urandom_range(0, 120000);
			else if (pick < 95)
				clock_ms = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				temp = $urandom_range(0, 700) - 50;
			else if (pick < 85)
				temp = $urandom_range(0, 4200);
			else
				temp = $signed(16'($urandom));
			hour = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 23) : $urandom_range(0, 31);
			send_pass(temp, hour, clock_ms);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight after reset every channel is disabled: a pass changes nothing
		send_pass(32767, 31, 32'hFFFF_FFFF);
		send_manual(3, 1'b1);
		drain();

		// one rule per channel, plus the disabled, manual-only and saturated cases
		plan = '{default: '0};
		plan[0].enable = 1'b1; plan[0].auto_en = 1'b1;
		plan[0].on_temp = 12'd320; plan[0].off_temp = 12'd400;
		plan[1].enable = 1'b1; plan[1].auto_en = 1'b1;
		plan[1].on_hour = 5'd8; plan[1].off_hour = 5'd18;
		plan[2].enable = 1'b1; plan[2].auto_en = 1'b1;
		plan[2].interval_min = 14'd1; plan[2].duration_s = 13'd10;
		plan[3].enable = 1'b1; plan[3].auto_en = 1'b1;
		plan[3].on_temp = 12'd4095; plan[3].off_temp = 12'd4095;
		plan[3].on_hour = 5'd0; plan[3].off_hour = 5'd24;
		plan[3].interval_min = 14'd1; plan[3].duration_s = 13'd1;
		plan[4].enable = 1'b1; plan[4].on_temp = 12'd100;
		plan[5].auto_en = 1'b1; plan[5].off_hour = 5'd31;
		plan[6] = '1;
		plan[7].enable = 1'b1; plan[7].auto_en = 1'b1; plan[7].off_temp = 12'd1;
		write_plan();

		// temperature extremes, hour edges and out-of-day hours, timer edges and wrap
		send_pass(-32768, 0, 32'd0);
		send_pass(32767, 23, 32'd0);
		send_pass(0, 31, 32'd60000);
		send_pass(319, 8, 32'd69999);
		send_pass(320, 17, 32'd70000);
		send_pass(401, 18, 32'hFFFF_FFFF);
		send_pass(400, 24, 32'd59999);
		for (int i = 0; i < N_CH; i++)
			send_manual(i, 1'b1);
		send_pass(500, 12, 32'd120000);
		send_manual(0, 1'b0);
		send_manual(4, 1'b0);
		send_manual(5, 1'b0);
		send_pass(-1, 7, 32'h7FFF_FFFF);
		send_pass(4095, 8, 32'h8000_0000);
		send_pass(4096, 0, 32'h8000_03E8);
		drain();

		// every register at its top value: empty hour window, longest timers
		plan = '{default: '1};
		write_plan();
		repeat (60) send_random_item();
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			for (int i = 0; i < N_CH; i++)
				plan[i] = random_setting();
			// one phase with every register cleared, one with the clock about to wrap
			if (phase == 4)
				plan = '{default: '0};
			if (phase == 5)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600000);
			calm <= (phase == 2);
			write_plan();
			repeat (PHASE_ITEMS) send_random_item();
			drain();
		end
		calm <= 1'b0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== multi_channel_relay_auto_controller.f =====
src/rca_pkg.sv
src/rca_ram.sv
src/rca_chan_eval.sv
src/multi_channel_relay_auto_controller.sv
src/rca_checker.sv
test/relay_state_checker.sv
test/multi_channel_relay_auto_controller_tb.sv
